// ===== sv/sigma_clipped_background_estimate_unit_macros.svh =====
// assertion macros for the sigma clipped background estimate unit
`ifndef SIGMA_CLIPPED_BACKGROUND_ESTIMATE_UNIT_MACROS_SVH
`define SIGMA_CLIPPED_BACKGROUND_ESTIMATE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SCBE_ASSERT(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("lbl failed");
`define SCBE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbl failed");
`else
`define SCBE_ASSERT(lbl, clk, rst, cond)
`define SCBE_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/scbe_pkg.sv =====
// shared types and constants of the sigma clipped background estimate unit
`default_nettype none
package scbe_pkg;
  localparam int CUT_W    = 24;
  localparam int ROUND_W  = 4;
  localparam int STATUS_W = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;
  localparam logic [ROUND_W-1:0] ROUNDS_RESET = 4'd10;

  typedef enum logic [STATUS_W-1:0] {
    ST_CONVERGED = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_EMPTY     = 2'd2
  } status_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_P1   = 8'b0000_0010,
    S_DIVM = 8'b0000_0100,
    S_P2   = 8'b0000_1000,
    S_DIVV = 8'b0001_0000,
    S_SQRT = 8'b0010_0000,
    S_UPD  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;
endpackage
`default_nettype wire

// ===== sv/scbe_store.sv =====
// sample memory, one port, registered read
`default_nettype none
module scbe_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [DW-1:0] wdata,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== sv/scbe_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module scbe_div #(
  parameter int N = 64,
  parameter int D = 17
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [N-1:0] dividend,
  input  wire logic [D-1:0] divisor,
  output logic              done,
  output logic      [N-1:0] quotient
);
  localparam int CNTW = $clog2(N + 1);
  logic [D-1:0]    rem;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [D:0]      rem_shift;
  logic            fits;

  assign rem_shift = {rem, quotient[N-1]};
  assign fits      = rem_shift >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(N);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      if (fits) begin
        rem      <= D'(rem_shift - {1'b0, divisor});
        quotient <= {quotient[N-2:0], 1'b1};
      end else begin
        rem      <= rem_shift[D-1:0];
        quotient <= {quotient[N-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/scbe_sqrt.sv =====
// digit by digit integer square root, one root bit per cycle
`default_nettype none
module scbe_sqrt #(
  parameter int W = 24
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [2*W-1:0] radicand,
  output logic                done,
  output logic      [W-1:0]   root
);
  localparam int CNTW = $clog2(W + 1);
  logic [2*W-1:0]  rad;
  logic [W+1:0]    rem;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [W+1:0]    rem_shift;
  logic [W+1:0]    trial;

  assign rem_shift = {rem[W-1:0], rad[2*W-1:2*W-2]};
  assign trial     = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[2*W-3:0], 2'b00};
      if (rem_shift >= trial) begin
        rem  <= rem_shift - trial;
        root <= {root[W-2:0], 1'b1};
      end else begin
        rem  <= rem_shift;
        root <= {root[W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/sigma_clipped_background_estimate_unit.sv =====
// Sigma clipped background estimate. Samples stream in one per cycle while
// the block is idle; each one is stored (up to MAX_SAMPLES, the rest are
// dropped) and the running min and max become the first cuts. The transaction
// with tlast starts the estimate, during which s_axis_tready is low. Each
// clipping round makes a summing pass and a squared distance pass over the n
// stored samples through the single memory read port, one divide for the mean
// and one for the variance on a shared bit-serial divider and a square root;
// the result then waits for m_axis_tready. A round that finds no sample inside
// the cuts ends after its summing pass. Mean and deviation come out in
// unsigned Q16.8 on one master transaction.
`default_nettype none
`include "sigma_clipped_background_estimate_unit_macros.svh"
module sigma_clipped_background_estimate_unit #(
  parameter int MAX_SAMPLES = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // sample[15:0]
  input  wire logic        s_axis_tlast,   // last_sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // background_mean[23:0], background_std[47:24], rounds_used[51:48],
  // status[53:52], zero pad[55:54]
  output logic [55:0]      m_axis_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data
);
  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int AW   = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SBW  = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int SUMW = SBW + CW;
  localparam int SQW  = 48 + CW;
  localparam int VW   = scbe_pkg::CUT_W;
  localparam logic [15:0] SMASK = 16'((17'(1) << SBW) - 17'(1));

  scbe_pkg::state_t state;
  logic [scbe_pkg::ROUND_W-1:0] max_rounds, round, limit;
  logic [CW-1:0]   count, idx, ct;
  logic [VW-1:0]   low_cut, upper_cut, prev_dev, mean, dev;
  logic [SUMW-1:0] sum;
  logic [SQW-1:0]  sumsq;
  logic [47:0]     sq;
  logic            v1, v2;

  logic [15:0]     x;
  logic [VW-1:0]   x8, v;
  logic [SBW-1:0]  rdata;
  logic            in_cuts, issue, pass_done, in_acc;
  logic [VW-1:0]   diff;

  logic            div_start, div_done, sqrt_start, sqrt_done;
  logic [SQW-1:0]  div_dividend, quot;
  logic [VW-1:0]   root;

  logic [VW+1:0]   hi_cut, two_dev;
  logic [VW-1:0]   lo_cut, ddiff;
  logic [VW+4:0]   ddiff20;
  logic            converged;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == scbe_pkg::S_IDLE);
  assign m_axis_tvalid = (state == scbe_pkg::S_OUT);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign limit         = (max_rounds == '0) ? scbe_pkg::ROUND_W'(1) : max_rounds;

  assign x  = s_axis_tdata & SMASK;
  assign x8 = VW'({x, 8'h00});
  assign v  = VW'({rdata, 8'h00});
  assign in_cuts = (v > low_cut) && (v < upper_cut);
  assign diff    = (v > mean) ? (v - mean) : (mean - v);

  assign issue = ((state == scbe_pkg::S_P1) || (state == scbe_pkg::S_P2)) && (idx != count);
  assign pass_done = (idx == count) && !v1 && !v2;

  scbe_store #(.DEPTH(MAX_SAMPLES), .AW(AW), .DW(SBW)) u_store (
    .clk   (clk),
    .we    (in_acc && (count < CW'(MAX_SAMPLES))),
    .addr  (in_acc ? count[AW-1:0] : idx[AW-1:0]),
    .wdata (x[SBW-1:0]),
    .rdata (rdata)
  );

  assign div_dividend = (state == scbe_pkg::S_P1) ?
                        (SQW'({sum, 8'h00}) + SQW'(ct >> 1)) : sumsq;

  scbe_div #(.N(SQW), .D(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (ct),
    .done     (div_done),
    .quotient (quot)
  );

  scbe_sqrt #(.W(VW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (quot[47:0]),
    .done     (sqrt_done),
    .root     (root)
  );

  // cut update and convergence test after each round
  assign two_dev   = {1'b0, dev, 1'b0};
  assign hi_cut    = (VW+2)'(mean) + two_dev;
  assign lo_cut    = ((VW+2)'(mean) >= two_dev) ? VW'((VW+2)'(mean) - two_dev) : '0;
  assign ddiff     = (dev > prev_dev) ? (dev - prev_dev) : (prev_dev - dev);
  assign ddiff20   = ((VW+5)'(ddiff) << 4) + ((VW+5)'(ddiff) << 2);
  assign converged = (dev == '0) || (ddiff20 < (VW+5)'(dev));

  assign div_start  = ((state == scbe_pkg::S_P1) && pass_done && (ct != '0)) ||
                      ((state == scbe_pkg::S_P2) && pass_done);
  assign sqrt_start = (state == scbe_pkg::S_DIVV) && div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= scbe_pkg::S_IDLE;
      max_rounds <= scbe_pkg::ROUNDS_RESET;
      count      <= '0;
      low_cut    <= '1;
      upper_cut  <= '0;
      prev_dev   <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_rounds <= cfg_data;
      end
      v1 <= issue;
      v2 <= v1 && (state == scbe_pkg::S_P2);
      unique case (state)
        scbe_pkg::S_IDLE: begin
          if (in_acc) begin
            if (count < CW'(MAX_SAMPLES)) begin
              count <= count + 1'b1;
              if (x8 < low_cut) low_cut <= x8;
              if (x8 > upper_cut) upper_cut <= x8;
            end
            if (s_axis_tlast) begin
              state <= scbe_pkg::S_P1;
            end
          end
        end
        scbe_pkg::S_P1: begin
          if (pass_done) begin
            state <= (ct == '0) ? scbe_pkg::S_OUT : scbe_pkg::S_DIVM;
          end
        end
        scbe_pkg::S_DIVM: begin
          if (div_done) state <= scbe_pkg::S_P2;
        end
        scbe_pkg::S_P2: begin
          if (pass_done) state <= scbe_pkg::S_DIVV;
        end
        scbe_pkg::S_DIVV: begin
          if (div_done) state <= scbe_pkg::S_SQRT;
        end
        scbe_pkg::S_SQRT: begin
          if (sqrt_done) state <= scbe_pkg::S_UPD;
        end
        scbe_pkg::S_UPD: begin
          if (hi_cut < (VW+2)'(upper_cut)) upper_cut <= VW'(hi_cut);
          if (lo_cut > low_cut) low_cut <= lo_cut;
          prev_dev <= dev;
          if (converged || (round == limit)) begin
            state <= scbe_pkg::S_OUT;
          end else begin
            state <= scbe_pkg::S_P1;
          end
        end
        scbe_pkg::S_OUT: begin
          if (m_axis_tready) begin
            state     <= scbe_pkg::S_IDLE;
            count     <= '0;
            low_cut   <= '1;
            upper_cut <= '0;
            prev_dev  <= '0;
          end
        end
        default: state <= scbe_pkg::S_IDLE;
      endcase
    end
  end

  // datapath registers of the round loop
  always_ff @(posedge clk) begin
    if (issue) idx <= idx + 1'b1;
    if (v1 && in_cuts && (state == scbe_pkg::S_P1)) begin
      sum <= sum + SUMW'(rdata);
      ct  <= ct + 1'b1;
    end
    sq <= in_cuts ? (48'(diff) * 48'(diff)) : '0;
    if (v2) sumsq <= sumsq + SQW'(sq);
    unique case (state)
      scbe_pkg::S_IDLE: begin
        idx   <= '0;
        sum   <= '0;
        ct    <= '0;
        round <= scbe_pkg::ROUND_W'(1);
      end
      scbe_pkg::S_P1: begin
        if (pass_done && (ct == '0)) begin
          mean <= '0;
          dev  <= '0;
          m_axis_tdata <= {2'b00, scbe_pkg::ST_EMPTY, round, {VW{1'b0}}, {VW{1'b0}}};
        end
      end
      scbe_pkg::S_DIVM: begin
        idx   <= '0;
        sumsq <= '0;
        if (div_done) mean <= quot[VW-1:0];
      end
      scbe_pkg::S_SQRT: begin
        if (sqrt_done) dev <= root;
      end
      scbe_pkg::S_UPD: begin
        idx   <= '0;
        sum   <= '0;
        ct    <= '0;
        round <= round + 1'b1;
        m_axis_tdata <= {2'b00,
                         converged ? scbe_pkg::ST_CONVERGED : scbe_pkg::ST_LIMIT,
                         round, dev, mean};
      end
      default: begin
      end
    endcase
  end

  `SCBE_ASSERT_IMPL(a_no_overlap, clk, rst, s_axis_tready, !m_axis_tvalid)
  `SCBE_ASSERT_IMPL(a_rounds_nonzero, clk, rst, m_axis_tvalid, m_axis_tdata[51:48] != 4'd0)
  `SCBE_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CW'(MAX_SAMPLES))
endmodule
`default_nettype wire

// ===== bench/scbe_result_checker.sv =====
// checker for the sigma clipped background estimate unit: predicts and compares results
`timescale 1ns / 100ps
`default_nettype none
module scbe_result_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // sample[15:0]
  input  wire logic        s_axis_tlast,   // last_sample
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // background_mean[23:0], background_std[47:24], rounds_used[51:48],
  // status[53:52], zero pad[55:54]
  input  wire logic [55:0] m_axis_tdata,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [3:0]  cfg_data,
  output int               fail_count,
  output int               pending_estimates,
  output int               estimates_seen
);
  localparam int WINDOW_DEPTH = 4096;

  typedef struct packed {
    logic [scbe_pkg::CUT_W-1:0]   mean;
    logic [scbe_pkg::CUT_W-1:0]   spread;
    logic [scbe_pkg::ROUND_W-1:0] rounds;
    scbe_pkg::status_t            status;
  } estimate_t;

  logic [15:0]                  window_store [WINDOW_DEPTH];
  int unsigned                  window_fill;
  logic [scbe_pkg::CUT_W-1:0]   low_cut;
  logic [scbe_pkg::CUT_W-1:0]   upper_cut;
  logic [scbe_pkg::ROUND_W-1:0] round_limit;
  estimate_t                    estimate_q [$];

  function automatic logic [31:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  // runs the clipping rounds over the current window
  function automatic estimate_t clip_window();
    estimate_t   e;
    int unsigned lim;
    logic [63:0] sum, sumsq, ct, hi, lo, d;
    logic [31:0] mean, dev, prev, v;
    logic [scbe_pkg::CUT_W-1:0] lc, hc;
    e.mean = 0;
    e.spread = 0;
    e.rounds = 0;
    e.status = scbe_pkg::ST_LIMIT;
    lc = low_cut;
    hc = upper_cut;
    prev = 0;
    mean = 0;
    dev = 0;
    lim = (round_limit == 0) ? 1 : round_limit;
    for (int rnd = 1; rnd <= lim; rnd++) begin
      e.rounds = scbe_pkg::ROUND_W'(rnd);
      sum = 0;
      sumsq = 0;
      ct = 0;
      for (int i = 0; i < window_fill; i++) begin
        v = {8'd0, window_store[i], 8'd0};
        if (v > lc && v < hc) begin
          sum += window_store[i];
          ct++;
        end
      end
      if (ct == 0) begin
        mean = 0;
        dev = 0;
        e.status = scbe_pkg::ST_EMPTY;
        break;
      end
      mean = 32'((sum * 256 + ct / 2) / ct);
      for (int i = 0; i < window_fill; i++) begin
        v = {8'd0, window_store[i], 8'd0};
        if (v > lc && v < hc) begin
          d = (v > mean) ? 64'(v - mean) : 64'(mean - v);
          sumsq += d * d;
        end
      end
      dev = int_sqrt(sumsq / ct);
      hi = 64'(mean) + 2 * 64'(dev);
      if (hi < 64'(hc)) hc = hi[scbe_pkg::CUT_W-1:0];
      lo = (64'(mean) >= 2 * 64'(dev)) ? 64'(mean) - 2 * 64'(dev) : 64'd0;
      if (lo > 64'(lc)) lc = lo[scbe_pkg::CUT_W-1:0];
      d = (dev > prev) ? 64'(dev - prev) : 64'(prev - dev);
      prev = dev;
      if (dev == 0 || d * 20 < 64'(dev)) begin
        e.status = scbe_pkg::ST_CONVERGED;
        break;
      end
    end
    e.mean = mean[scbe_pkg::CUT_W-1:0];
    e.spread = dev[scbe_pkg::CUT_W-1:0];
    return e;
  endfunction

  assign pending_estimates = estimate_q.size();

  always @(posedge clk) begin
    estimate_t   want;
    logic [31:0] x8;
    if (rst) begin
      window_fill <= 0;
      low_cut <= '1;
      upper_cut <= '0;
      round_limit <= scbe_pkg::ROUNDS_RESET;
      fail_count <= 0;
      estimates_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) round_limit <= cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        // blocking updates here so the estimate sees this sample
        if (window_fill < WINDOW_DEPTH) begin
          x8 = {8'd0, s_axis_tdata, 8'd0};
          window_store[window_fill] = s_axis_tdata;
          window_fill = window_fill + 1;
          if (x8 < low_cut) low_cut = x8[scbe_pkg::CUT_W-1:0];
          if (x8 > upper_cut) upper_cut = x8[scbe_pkg::CUT_W-1:0];
        end
        if (s_axis_tlast) begin
          estimate_q.push_back(clip_window());
          window_fill = 0;
          low_cut = '1;
          upper_cut = '0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        estimates_seen <= estimates_seen + 1;
        if (estimate_q.size() == 0) begin
          $display("%0t: unexpected result transaction, actual %h", $time, m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = estimate_q.pop_front();
          if (m_axis_tdata[23:0] !== want.mean ||
              m_axis_tdata[47:24] !== want.spread ||
              m_axis_tdata[51:48] !== want.rounds ||
              m_axis_tdata[53:52] !== want.status) begin
            $display("%0t: mismatch, expected mean %h std %h rounds %0d status %0d", $time,
                     want.mean, want.spread, want.rounds, want.status);
            $display("%0t:          actual mean %h std %h rounds %0d status %0d", $time,
                     m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tdata[51:48],
                     m_axis_tdata[53:52]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== bench/tb_sigma_clipped_background_estimate_unit.sv =====
// testbench top for the sigma clipped background estimate unit: stimulus and verdict
`timescale 1ns / 100ps
`default_nettype none
module tb_sigma_clipped_background_estimate_unit;

  localparam int CYCLE_LIMIT = 4000000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;
  int          fail_count;
  int          pending_estimates;
  int          estimates_seen;
  int          cycle_count;
  int          samples_sent;
  int          windows_sent;
  bit          hold_receiver;
  bit          no_gaps;

  sigma_clipped_background_estimate_unit u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  scbe_result_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_estimates(pending_estimates),
    .estimates_seen(estimates_seen)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tlast = 0;
    m_axis_tready = 0;
    cfg_valid = 0;
    cfg_data = 0;
    hold_receiver = 0;
    no_gaps = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[sigma_clipped_background_estimate_unit] ERROR");
      $finish;
    end
  end
  initial cycle_count = 0;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // receiver side, with a long hold-off on request
  initial begin
    int g;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_receiver) begin
        m_axis_tready <= 0;
        repeat (3000) @(posedge clk);
        hold_receiver = 0;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          m_axis_tready <= 1;
        end else begin
          m_axis_tready <= 0;
          repeat (g - 1) @(posedge clk);
        end
      end
    end
  end

  task automatic send_sample(input logic [15:0] value, input logic last);
    bit rdy;
    int g;
    s_axis_tvalid <= 1;
    s_axis_tdata <= value;
    s_axis_tlast <= last;
    do begin
      @(negedge clk);
      rdy = s_axis_tready;
      @(posedge clk);
    end while (!rdy);
    samples_sent++;
    if (last) windows_sent++;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // sample shapes: 0 full range, 1 cluster with outliers, 2 constant
  task automatic send_window(input int count, input int shape);
    logic [15:0] base;
    logic [15:0] v;
    int spread;
    base = 16'($urandom);
    spread = $urandom_range(1, 400);
    for (int i = 0; i < count; i++) begin
      case (shape)
        0: begin
          v = 16'($urandom);
        end
        1: begin
          if ($urandom_range(0, 9) == 0) v = 16'($urandom);
          else v = base + 16'($urandom_range(0, spread)) - 16'(spread / 2);
        end
        default: begin
          v = base;
        end
      endcase
      send_sample(v, i == count - 1);
    end
  endtask

  // the result count is looked at between edges so a window just closed is seen
  task automatic wait_drained();
    s_axis_tvalid <= 0;
    @(negedge clk);
    while (pending_estimates != 0) @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_rounds(input logic [3:0] value);
    bit rdy;
    cfg_valid <= 1;
    cfg_data <= value;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 0;
  endtask

  initial begin
    int n;
    samples_sent = 0;
    windows_sent = 0;
    @(negedge rst);
    @(posedge clk);

    // round limit zero acts as one
    write_rounds(4'd0);
    send_sample(16'd0, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'h8000, 1'b1);
    wait_drained();
    write_rounds(4'd15);
    // constant window gives zero deviation
    send_window(5, 2);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b1);
    send_window(10, 1);
    wait_drained();
    write_rounds(4'd1);
    send_window(6, 1);
    wait_drained();
    write_rounds(4'd10);

    while (samples_sent < 1100) begin
      wait_drained();
      write_rounds(4'($urandom));
      no_gaps = ($urandom_range(0, 4) == 0);
      if (windows_sent > 20 && windows_sent < 28) hold_receiver = 1;
      n = $urandom_range(3, 6);
      for (int w = 0; w < n; w++) begin
        if ($urandom_range(0, 19) == 0) send_window($urandom_range(100, 250), $urandom_range(0, 2));
        else send_window($urandom_range(1, 40), $urandom_range(0, 9) < 6 ? 1 :
                         $urandom_range(0, 9) < 8 ? 0 : 2);
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);
    $display("covered %0d samples in %0d windows, %0d estimates checked", samples_sent,
             windows_sent, estimates_seen);
    $display("round limits from 0 to 15, long output stall, constant and clustered windows");
    if (fail_count == 0 && pending_estimates == 0) begin
      $display("[sigma_clipped_background_estimate_unit] OK");
    end else begin
      $display("[sigma_clipped_background_estimate_unit] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
